// ===== hw/rtl/job_shop_makespan_evaluator_top_assert.svh =====
// Assertion macros for the top level, which checks its own logic.
`ifndef JOB_SHOP_MAKESPAN_EVALUATOR_TOP_ASSERT_SVH
`define JOB_SHOP_MAKESPAN_EVALUATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define JSME_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define JSME_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/jsme_pkg.sv =====
package jsme_pkg;

    // Field widths
    localparam int IDX_W   = 6;
    localparam int DUR_W   = 16;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 36;
    localparam int RUNS_W  = 5;
    localparam int FRAC_W  = 4;
    localparam int VALUE_W = 40;

    // Parameter defaults
    localparam int DEF_MAX_MACHINES = 64;
    localparam int DEF_MAX_JOBS     = 64;
    localparam int DEF_NUM_RUNS     = 16;

    // Result kinds
    localparam logic KIND_MAKESPAN = 1'b0;
    localparam logic KIND_AVERAGE  = 1'b1;

    // End-of-run event from the update stage to the result unit
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] makespan;
    } run_done_t;

endpackage

// ===== hw/rtl/jsme_ram.sv =====
module jsme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port (old data on a same-address clash)
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/jsme_div.sv =====
module jsme_div #(
    parameter int DIVISOR = jsme_pkg::DEF_NUM_RUNS
) (
    input  logic                         clk,
    input  logic                         rstn,
    input  logic                         start,
    input  logic [jsme_pkg::VALUE_W-1:0] dividend,
    output logic                         done,
    output logic [jsme_pkg::VALUE_W-1:0] quotient
);

    // Divide by a constant of at most 16 as a multiply by its scaled reciprocal:
    // q = (x * ceil(2^SCALE / DIVISOR)) >> SCALE, exact for every 40-bit x.
    localparam int XW      = jsme_pkg::VALUE_W;
    localparam int SCALE   = XW + 4;
    localparam int CHUNK_W = 15;
    localparam int STEPS   = (SCALE + CHUNK_W) / CHUNK_W;
    localparam int RECIP_W = STEPS * CHUNK_W;
    localparam int ACC_W   = XW + CHUNK_W + 1;
    localparam int QSH     = SCALE - (STEPS - 1) * CHUNK_W;
    localparam int CNT_W   = $clog2(STEPS + 1);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SCALE) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [XW-1:0]         x_reg;
    logic [RECIP_W-1:0]    recip_reg;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [XW+CHUNK_W-1:0] prod;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;

    // One reciprocal slice per cycle, low slice first; the sum is kept shifted
    // down by one slice each step so the final bits line up with the quotient
    always_comb begin
        prod     = x_reg * recip_reg[CHUNK_W-1:0];
        acc_next = (acc_reg >> CHUNK_W) + ACC_W'(prod);
    end

    // Step control
    always_ff @(posedge clk) begin
        if (!rstn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(STEPS);
        end else if (run_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Dividend, remaining reciprocal slices and partial product sum
    always_ff @(posedge clk) begin
        if (start) begin
            x_reg     <= dividend;
            recip_reg <= RECIP;
            acc_reg   <= '0;
        end else if (run_reg) begin
            recip_reg <= recip_reg >> CHUNK_W;
            acc_reg   <= acc_next;
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg[QSH +: XW];

endmodule

// ===== hw/rtl/jsme_sched.sv =====
module jsme_sched #(
    parameter int MAX_MACHINES = jsme_pkg::DEF_MAX_MACHINES,
    parameter int MAX_JOBS     = jsme_pkg::DEF_MAX_JOBS
) (
    input  logic                         clk,
    input  logic                         rstn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [jsme_pkg::IDX_W-1:0]   machine_index,
    input  logic [jsme_pkg::IDX_W-1:0]   job_index,
    input  logic [jsme_pkg::DUR_W-1:0]   task_duration,
    input  logic                         last_task,
    input  logic                         res_busy,
    output jsme_pkg::run_done_t          done
);

    localparam int IDX_SPAN   = 2 ** jsme_pkg::IDX_W;
    localparam int MACH_DEPTH = (MAX_MACHINES < IDX_SPAN) ? MAX_MACHINES : IDX_SPAN;
    localparam int JOB_DEPTH  = (MAX_JOBS < IDX_SPAN) ? MAX_JOBS : IDX_SPAN;
    localparam int MACH_AW    = (MACH_DEPTH > 1) ? $clog2(MACH_DEPTH) : 1;
    localparam int JOB_AW     = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int TW         = jsme_pkg::TIME_W;

    logic                accept, retire, in_ok;
    logic [MACH_AW-1:0]  in_maddr;
    logic [JOB_AW-1:0]   in_jaddr;

    // Update stage
    logic                s1_valid_reg, s1_last_reg, s1_ok_reg;
    logic                s1_mvld_reg, s1_jvld_reg, s1_fwd_reg;
    logic [MACH_AW-1:0]  s1_maddr_reg;
    logic [JOB_AW-1:0]   s1_jaddr_reg;
    logic [jsme_pkg::DUR_W-1:0] s1_dur_reg;

    // Record of the last retired task, for the read that overlapped its write
    logic [MACH_AW-1:0]  fw_maddr_reg;
    logic [JOB_AW-1:0]   fw_jaddr_reg;
    logic [TW-1:0]       fw_finish_reg;
    logic                fw_ok_reg, fw_clr_reg;

    logic [MACH_DEPTH-1:0] mvld_reg, mvld_next;
    logic [JOB_DEPTH-1:0]  jvld_reg, jvld_next;
    logic [TW-1:0]         mk_reg, mk_new;

    logic [TW-1:0] m_rdata, j_rdata, m_time, j_time, start_time, finish;
    logic [TW:0]   sum_time;

    assign in_maddr = MACH_AW'(machine_index);
    assign in_jaddr = JOB_AW'(job_index);
    assign in_ok    = (32'(machine_index) < 32'(MAX_MACHINES)) &&
                      (32'(job_index) < 32'(MAX_JOBS));

    assign retire  = s1_valid_reg && (!s1_last_reg || !res_busy);
    assign s_ready = !s1_valid_reg || retire;
    assign accept  = s_valid && s_ready;

    // Ready-time tables
    jsme_ram #(.WIDTH(TW), .DEPTH(MACH_DEPTH)) u_mach_ram (
        .clk   (clk),
        .we    (retire && s1_ok_reg),
        .waddr (s1_maddr_reg),
        .wdata (finish),
        .re    (accept),
        .raddr (in_maddr),
        .rdata (m_rdata)
    );

    jsme_ram #(.WIDTH(TW), .DEPTH(JOB_DEPTH)) u_job_ram (
        .clk   (clk),
        .we    (retire && s1_ok_reg),
        .waddr (s1_jaddr_reg),
        .wdata (finish),
        .re    (accept),
        .raddr (in_jaddr),
        .rdata (j_rdata)
    );

    // Operand select: cleared table, forwarded finish, or RAM data
    always_comb begin
        if (s1_fwd_reg && fw_clr_reg) begin
            m_time = '0;
        end else if (s1_fwd_reg && fw_ok_reg && (fw_maddr_reg == s1_maddr_reg)) begin
            m_time = fw_finish_reg;
        end else begin
            m_time = s1_mvld_reg ? m_rdata : '0;
        end

        if (s1_fwd_reg && fw_clr_reg) begin
            j_time = '0;
        end else if (s1_fwd_reg && fw_ok_reg && (fw_jaddr_reg == s1_jaddr_reg)) begin
            j_time = fw_finish_reg;
        end else begin
            j_time = s1_jvld_reg ? j_rdata : '0;
        end
    end

    // Finish time, saturating, and running makespan
    assign start_time = (j_time > m_time) ? j_time : m_time;
    assign sum_time   = {1'b0, start_time} + (TW + 1)'(s1_dur_reg);
    assign finish     = sum_time[TW] ? '1 : sum_time[TW-1:0];
    assign mk_new     = (s1_ok_reg && (finish > mk_reg)) ? finish : mk_reg;

    // Entry valid bits: set on write, all cleared at end of run
    always_comb begin
        mvld_next = mvld_reg;
        jvld_next = jvld_reg;
        if (retire && s1_ok_reg) begin
            mvld_next[s1_maddr_reg] = 1'b1;
            jvld_next[s1_jaddr_reg] = 1'b1;
        end
        if (retire && s1_last_reg) begin
            mvld_next = '0;
            jvld_next = '0;
        end
    end

    // Control state
    always_ff @(posedge clk) begin
        if (!rstn) begin
            s1_valid_reg <= 1'b0;
            mvld_reg     <= '0;
            jvld_reg     <= '0;
            mk_reg       <= '0;
            fw_ok_reg    <= 1'b0;
            fw_clr_reg   <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (retire) begin
                s1_valid_reg <= 1'b0;
            end
            mvld_reg <= mvld_next;
            jvld_reg <= jvld_next;
            if (retire) begin
                mk_reg     <= s1_last_reg ? '0 : mk_new;
                fw_ok_reg  <= s1_ok_reg;
                fw_clr_reg <= s1_last_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk) begin
        if (accept) begin
            s1_maddr_reg <= in_maddr;
            s1_jaddr_reg <= in_jaddr;
            s1_dur_reg   <= task_duration;
            s1_last_reg  <= last_task;
            s1_ok_reg    <= in_ok;
            s1_mvld_reg  <= mvld_reg[in_maddr];
            s1_jvld_reg  <= jvld_reg[in_jaddr];
            s1_fwd_reg   <= retire;
        end
        if (retire) begin
            fw_maddr_reg  <= s1_maddr_reg;
            fw_jaddr_reg  <= s1_jaddr_reg;
            fw_finish_reg <= finish;
        end
    end

    assign done.valid    = retire && s1_last_reg;
    assign done.makespan = mk_new;

endmodule

// ===== hw/rtl/jsme_result.sv =====
module jsme_result #(
    parameter int NUM_RUNS = jsme_pkg::DEF_NUM_RUNS
) (
    input  logic                         clk,
    input  logic                         rstn,
    input  jsme_pkg::run_done_t          done,
    output logic                         busy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_result_kind,
    output logic [jsme_pkg::VALUE_W-1:0] m_result_value,
    output logic                         m_last_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAKESPAN,
        ST_AVERAGE
    } state_t;

    state_t                        state_reg;
    logic [jsme_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [jsme_pkg::RUNS_W-1:0]   runs_reg, runs_next;
    logic [jsme_pkg::TIME_W-1:0]   mk_out_reg;
    logic                          avg_pend_reg;
    logic                          avg_hit;
    logic                          div_done;
    logic [jsme_pkg::VALUE_W-1:0]  div_quo;

    // Accumulate the finished run
    assign sum_next  = sum_reg + jsme_pkg::SUM_W'(done.makespan);
    assign runs_next = runs_reg + 1'b1;
    assign avg_hit   = runs_next >= jsme_pkg::RUNS_W'(NUM_RUNS);

    // Average = sum * 16 / NUM_RUNS
    jsme_div #(.DIVISOR(NUM_RUNS)) u_div (
        .clk      (clk),
        .rstn     (rstn),
        .start    (done.valid && avg_hit),
        .dividend ({sum_next, jsme_pkg::FRAC_W'(0)}),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Result sequencer
    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            runs_reg     <= '0;
            avg_pend_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (done.valid) begin
                        mk_out_reg   <= done.makespan;
                        avg_pend_reg <= avg_hit;
                        state_reg    <= ST_MAKESPAN;
                        if (avg_hit) begin
                            sum_reg  <= '0;
                            runs_reg <= '0;
                        end else begin
                            sum_reg  <= sum_next;
                            runs_reg <= runs_next;
                        end
                    end
                end
                ST_MAKESPAN: begin
                    if (m_ready) begin
                        state_reg <= avg_pend_reg ? ST_AVERAGE : ST_IDLE;
                    end
                end
                ST_AVERAGE: begin
                    if (div_done && m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign m_valid        = (state_reg == ST_MAKESPAN) ||
                            ((state_reg == ST_AVERAGE) && div_done);
    assign m_result_kind  = (state_reg == ST_AVERAGE) ? jsme_pkg::KIND_AVERAGE
                                                      : jsme_pkg::KIND_MAKESPAN;
    assign m_result_value = (state_reg == ST_AVERAGE) ? div_quo
                                                      : jsme_pkg::VALUE_W'(mk_out_reg);
    assign m_last_result  = (state_reg == ST_AVERAGE) || !avg_pend_reg;

endmodule

// ===== hw/rtl/job_shop_makespan_evaluator_top.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  machine_index, job_index, task_duration, last_task
// m_        out        m_valid / m_ready  result_kind, result_value, last_result
//
// One task per cycle unless stalled: both ready-time RAMs are read at acceptance and written
// on retirement; the task retired on the acceptance edge is forwarded into the next one.
// A last task waits in the update stage while the previous run's results are pending.
// The average follows the run makespan after a reciprocal multiply.
// Reset is synchronous, active low; entry valid bits clear at once, no clearing pass.
`include "job_shop_makespan_evaluator_top_assert.svh"

module job_shop_makespan_evaluator_top #(
    parameter int MAX_MACHINES = jsme_pkg::DEF_MAX_MACHINES,
    parameter int MAX_JOBS     = jsme_pkg::DEF_MAX_JOBS,
    parameter int NUM_RUNS     = jsme_pkg::DEF_NUM_RUNS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [jsme_pkg::IDX_W-1:0]   s_machine_index,
    input  logic [jsme_pkg::IDX_W-1:0]   s_job_index,
    input  logic [jsme_pkg::DUR_W-1:0]   s_task_duration,
    input  logic                         s_last_task,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_result_kind,
    output logic [jsme_pkg::VALUE_W-1:0] m_result_value,
    output logic                         m_last_result
);

    jsme_pkg::run_done_t run_done;
    logic                res_busy;

    // Task timing against the ready-time tables
    jsme_sched #(
        .MAX_MACHINES (MAX_MACHINES),
        .MAX_JOBS     (MAX_JOBS)
    ) u_sched (
        .clk           (aclk),
        .rstn          (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .machine_index (s_machine_index),
        .job_index     (s_job_index),
        .task_duration (s_task_duration),
        .last_task     (s_last_task),
        .res_busy      (res_busy),
        .done          (run_done)
    );

    // Per-run makespan, sum and average
    jsme_result #(
        .NUM_RUNS (NUM_RUNS)
    ) u_result (
        .clk            (aclk),
        .rstn           (aresetn),
        .done           (run_done),
        .busy           (res_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_result_value (m_result_value),
        .m_last_result  (m_last_result)
    );

    // A run ends only when the result unit is free
    `JSME_ASSERT_NOW(a_done_when_idle, aclk, aresetn, run_done.valid, !res_busy, "run end while results pending")

    // An average transaction always closes its run's results
    `JSME_ASSERT_NOW(a_avg_is_last, aclk, aresetn, m_valid && (m_result_kind == jsme_pkg::KIND_AVERAGE), m_last_result, "average not marked last")

    // A makespan followed by an average keeps the result unit busy
    `JSME_ASSERT_NEXT(a_avg_follows, aclk, aresetn, m_valid && m_ready && (m_result_kind == jsme_pkg::KIND_MAKESPAN) && !m_last_result, res_busy, "average lost after makespan")

endmodule

// ===== tb/job_shop_makespan_evaluator_top_test.sv =====
`timescale 1ns / 100ps

module job_shop_makespan_evaluator_top_test;

    localparam int MACHINES   = jsme_pkg::DEF_MAX_MACHINES;
    localparam int JOBS       = jsme_pkg::DEF_MAX_JOBS;
    localparam int RUNS       = jsme_pkg::DEF_NUM_RUNS;
    localparam int IDX_W      = jsme_pkg::IDX_W;
    localparam int DUR_W      = jsme_pkg::DUR_W;
    localparam int TIME_W     = jsme_pkg::TIME_W;
    localparam int SUM_W      = jsme_pkg::SUM_W;
    localparam int VALUE_W    = jsme_pkg::VALUE_W;
    localparam int FRAC_W     = jsme_pkg::FRAC_W;
    localparam int RANDOM_TASKS = 1080;

    typedef struct {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } makespan_result_t;

    // Shadow of the evaluator: ready-time tables, run makespan and run average
    class makespan_predictor;
        bit [TIME_W-1:0]  machine_free [MACHINES];
        bit [TIME_W-1:0]  job_free [JOBS];
        bit [TIME_W-1:0]  span;
        bit [SUM_W-1:0]   span_total;
        int unsigned      runs_seen;
        makespan_result_t pending_makespans [$];
        int unsigned      errors;

        function void clear_run();
            foreach (machine_free[k]) machine_free[k] = '0;
            foreach (job_free[k]) job_free[k] = '0;
            span = '0;
        endfunction

        function new();
            clear_run();
            span_total = '0;
            runs_seen  = 0;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return pending_makespans.size();
        endfunction

        function void push_result(logic kind, logic [VALUE_W-1:0] value, logic last);
            makespan_result_t r;
            r.kind  = kind;
            r.value = value;
            r.last  = last;
            pending_makespans.push_back(r);
        endfunction

        // Accepted task: advance the schedule and queue any run results
        function void note_task(bit [IDX_W-1:0] mach, bit [IDX_W-1:0] job,
                                bit [DUR_W-1:0] dur, bit fin);
            bit [TIME_W:0]    finish;
            bit [TIME_W-1:0]  start;
            bit [VALUE_W-1:0] avg;
            if (mach < MACHINES && job < JOBS) begin
                start  = (job_free[job] > machine_free[mach]) ? job_free[job]
                                                              : machine_free[mach];
                finish = {1'b0, start} + dur;
                // saturate at all ones
                if (finish[TIME_W])
                    finish = {1'b0, {TIME_W{1'b1}}};
                machine_free[mach] = finish[TIME_W-1:0];
                job_free[job]      = finish[TIME_W-1:0];
                if (finish[TIME_W-1:0] > span)
                    span = finish[TIME_W-1:0];
            end
            if (!fin)
                return;
            span_total += span;
            runs_seen++;
            if (runs_seen >= RUNS) begin
                avg = {span_total, {FRAC_W{1'b0}}} / RUNS;
                push_result(jsme_pkg::KIND_MAKESPAN, VALUE_W'(span), 1'b0);
                push_result(jsme_pkg::KIND_AVERAGE, avg, 1'b1);
                span_total = '0;
                runs_seen  = 0;
            end else begin
                push_result(jsme_pkg::KIND_MAKESPAN, VALUE_W'(span), 1'b1);
            end
            clear_run();
        endfunction

        // Accepted result: compare with the oldest expectation
        function void check_result(logic kind, logic [VALUE_W-1:0] value, logic last);
            makespan_result_t exp_r;
            if (pending_makespans.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result kind %b value %h last %b",
                             $realtime, kind, value, last);
                return;
            end
            exp_r = pending_makespans.pop_front();
            if (kind !== exp_r.kind || value !== exp_r.value || last !== exp_r.last) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp kind %b value %h last %b, got %b %h %b",
                             $realtime, exp_r.kind, exp_r.value, exp_r.last,
                             kind, value, last);
            end
        endfunction
    endclass

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [IDX_W-1:0]   s_machine_index = '0;
    logic [IDX_W-1:0]   s_job_index     = '0;
    logic [DUR_W-1:0]   s_task_duration = '0;
    logic               s_last_task     = 1'b0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic               m_result_kind;
    logic [VALUE_W-1:0] m_result_value;
    logic               m_last_result;

    makespan_predictor book = new();

    int unsigned tasks_sent    = 0;
    int unsigned tx_burst_left = 0;
    int unsigned tx_gap_max    = 6;

    int unsigned rx_mode      = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_phase     = 0;

    job_shop_makespan_evaluator_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_machine_index (s_machine_index),
        .s_job_index     (s_job_index),
        .s_task_duration (s_task_duration),
        .s_last_task     (s_last_task),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_result_value  (m_result_value),
        .m_last_result   (m_last_result)
    );

    always #5 aclk = ~aclk;

    // Result side: check each transaction, then stall on a changing pattern
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_result(m_result_kind, m_result_value, m_last_result);
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(16, 200);
        end else begin
            rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 5) == 0);
            default: m_ready <= (rx_phase % 23) >= 12;
        endcase
    end

    // One task transaction, followed by a gap when the burst runs out
    task automatic send_task(input bit [IDX_W-1:0] mach, input bit [IDX_W-1:0] job,
                             input bit [DUR_W-1:0] dur, input bit fin);
        s_valid         <= 1'b1;
        s_machine_index <= mach;
        s_job_index     <= job;
        s_task_duration <= dur;
        s_last_task     <= fin;
        do @(posedge aclk); while (!s_ready);
        book.note_task(mach, job, dur, fin);
        tasks_sent++;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, tx_gap_max)) @(posedge aclk);
            tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(0, 10);
        end
    endtask

    // Hold off the sender until every expected result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge aclk);
    endtask

    // One schedule run with random content; a narrow one shares few machines and jobs
    task automatic random_run(input int unsigned len, input bit narrow);
        bit [IDX_W-1:0] mach;
        bit [IDX_W-1:0] job;
        bit [DUR_W-1:0] dur;
        for (int unsigned k = 0; k < len; k++) begin
            mach = IDX_W'(narrow ? $urandom_range(0, 3) : $urandom);
            job  = IDX_W'(narrow ? $urandom_range(0, 3) : $urandom);
            case ($urandom_range(0, 7))
                0:       dur = '0;
                1:       dur = '1;
                2, 3:    dur = DUR_W'($urandom_range(0, 15));
                default: dur = DUR_W'($urandom);
            endcase
            send_task(mach, job, dur, k == len - 1);
        end
    endtask

    // Stimulus
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, shared machines and jobs back to back
        send_task(6'd0,  6'd0,  16'h0000, 1'b0);
        send_task(6'd63, 6'd63, 16'hFFFF, 1'b0);
        send_task(6'd63, 6'd0,  16'h0001, 1'b0);
        send_task(6'd0,  6'd63, 16'h8000, 1'b0);
        send_task(6'd5,  6'd7,  16'h0003, 1'b0);
        send_task(6'd5,  6'd8,  16'h0004, 1'b0);
        send_task(6'd9,  6'd8,  16'h0005, 1'b0);
        send_task(6'd9,  6'd7,  16'h0002, 1'b1);
        // single-task runs: empty makespan and maximum duration
        send_task(6'd12, 6'd34, 16'h0000, 1'b1);
        send_task(6'd33, 6'd17, 16'hFFFF, 1'b1);
        // alternating bit patterns
        send_task(6'h2A, 6'h15, 16'hAAAA, 1'b0);
        send_task(6'h15, 6'h2A, 16'h5555, 1'b0);
        send_task(6'h2A, 6'h2A, 16'h5555, 1'b1);
        drain();

        // random runs, mostly short, some on a few shared resources
        while (tasks_sent < RANDOM_TASKS) begin
            if ($urandom_range(0, 4) == 0)
                random_run($urandom_range(1, 3), 1'($urandom_range(0, 1)));
            else
                random_run($urandom_range(4, 40), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0)
                drain();
        end
        drain();

        // a few more runs after the pause, crossing another average boundary
        for (int k = 0; k < 20; k++)
            random_run($urandom_range(1, 20), 1'($urandom_range(0, 1)));

        drain();
        repeat (40) @(posedge aclk);
        if (book.errors == 0)
            $display("PASS job_shop_makespan_evaluator_top");
        else
            $display("FAIL job_shop_makespan_evaluator_top");
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("FAIL job_shop_makespan_evaluator_top");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/jsme_pkg.sv
hw/rtl/jsme_ram.sv
hw/rtl/jsme_div.sv
hw/rtl/jsme_sched.sv
hw/rtl/jsme_result.sv
hw/rtl/job_shop_makespan_evaluator_top.sv
tb/job_shop_makespan_evaluator_top_test.sv
